### hw/rtl/pwn_pkg.sv
// pwn_pkg: shared types and constants for the winding-number block
// request codes, controller states, command/status structs, size defaults
// no dependencies
package pwn_pkg;

  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_COORD_BITS   = 32;

  // result field width and saturation bound
  localparam int WIND_W   = 10;
  localparam int WIND_MAX = 256;

  // request codes
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_SUM,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic append;
    logic clear;
    logic load_pt;
    logic step;
    logic sum;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic short_poly;
    logic walk_end;
  } sts_t;

endpackage

### hw/rtl/pwn_ctrl.sv
// pwn_ctrl: controller state machine for the winding-number block
// decodes requests and sequences the edge walk, sum and result strobe
// depends on pwn_pkg
module pwn_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    req_type,
  input  pwn_pkg::sts_t sts,
  output pwn_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);
  import pwn_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start && req_type == REQ_QUERY) begin
          state_next = sts.short_poly ? S_SUM : S_WALK;
        end
      end
      S_WALK: begin
        if (sts.walk_end) begin
          state_next = S_SUM;
        end
      end
      S_SUM:   state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (req_type)
            REQ_APPEND: cmd.append  = 1'b1;
            REQ_QUERY:  cmd.load_pt = 1'b1;
            REQ_CLEAR:  cmd.clear   = 1'b1;
            default: ;
          endcase
        end
      end
      S_WALK:  cmd.step = 1'b1;
      S_SUM:   cmd.sum  = 1'b1;
      S_OUT:   done     = 1'b1;
      default: ;
    endcase
  end

endmodule

### hw/rtl/pwn_dp.sv
// pwn_dp: datapath of the winding-number block
// vertex memory, count and overflow flag, edge compare, crossing accumulators
// depends on pwn_pkg
module pwn_dp #(
  parameter int MAX_VERTICES = pwn_pkg::DEF_MAX_VERTICES,
  parameter int COORD_BITS   = pwn_pkg::DEF_COORD_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pwn_pkg::cmd_t                    cmd,
  input  logic signed [COORD_BITS-1:0]     coord_x,
  input  logic signed [COORD_BITS-1:0]     coord_y,
  output pwn_pkg::sts_t                    sts,
  output logic signed [pwn_pkg::WIND_W-1:0] winding,
  output logic                             inside_res,
  output logic                             on_vertex,
  output logic                             overflowed
);
  import pwn_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int SW = (CW + 2 > WIND_W + 1) ? CW + 2 : WIND_W + 1;

  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_VERTICES);
  localparam logic [CW-1:0] COUNT_TWO  = CW'(2);
  localparam logic [CW-1:0] COUNT_ONE  = CW'(1);
  localparam logic signed [CW:0]   ACC_ONE = (CW+1)'(1);
  localparam logic signed [SW-1:0] SAT_HI = SW'(WIND_MAX);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(WIND_MAX);

  logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];

  logic [CW-1:0] vcount;
  logic          ovf;
  logic          full;

  logic signed [COORD_BITS-1:0] px, py;
  logic signed [COORD_BITS-1:0] rd_x, rd_y;
  logic signed [COORD_BITS-1:0] ax, ay;
  logic [CW-1:0] rd_ptr;
  logic          dat_vld;
  logic          rd_last;
  logic          have_prev;
  logic          hit;
  logic signed [CW:0] w, hw;

  logic issue, eval, hit_now;
  logic signed [CW:0]   hw_half;
  logic signed [SW-1:0] total;
  logic signed [SW-1:0] sat;

  assign full    = (vcount >= COUNT_FULL);
  assign issue   = cmd.step && (rd_ptr < vcount);
  assign eval    = cmd.step && dat_vld && have_prev;
  assign hit_now = eval && (ax == px) && (ay == py);

  assign sts.short_poly = (vcount < COUNT_TWO);
  assign sts.walk_end   = eval && (hit_now || rd_last);

  // vertex memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      mem_x[vcount[AW-1:0]] <= coord_x;
      mem_y[vcount[AW-1:0]] <= coord_y;
    end
    rd_x <= mem_x[rd_ptr[AW-1:0]];
    rd_y <= mem_y[rd_ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0;
      ovf    <= 1'b0;
    end else if (cmd.clear) begin
      vcount <= '0;
      ovf    <= 1'b0;
    end else if (cmd.append) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        vcount <= vcount + COUNT_ONE;
      end
    end
  end

  // edge walk
  always_ff @(posedge clk) begin
    if (rst) begin
      dat_vld   <= 1'b0;
      have_prev <= 1'b0;
      hit       <= 1'b0;
    end else if (cmd.load_pt) begin
      dat_vld   <= 1'b0;
      have_prev <= 1'b0;
      hit       <= 1'b0;
    end else if (cmd.step) begin
      dat_vld <= issue;
      if (dat_vld) begin
        have_prev <= 1'b1;
      end
      if (hit_now) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pt) begin
      px     <= coord_x;
      py     <= coord_y;
      rd_ptr <= '0;
      w      <= '0;
      hw     <= '0;
    end else if (cmd.step) begin
      if (issue) begin
        rd_ptr  <= rd_ptr + COUNT_ONE;
        rd_last <= (rd_ptr == vcount - COUNT_ONE);
      end
      if (dat_vld) begin
        ax <= rd_x;
        ay <= rd_y;
      end
      // crossing rule on edge (prev, current) when the start x is at or right of the point
      if (eval && !hit_now && ax >= px) begin
        if (ay < py) begin
          if (rd_y > py) begin
            w <= w + ACC_ONE;
          end else if (rd_y == py) begin
            hw <= hw + ACC_ONE;
          end
        end else if (ay > py) begin
          if (rd_y < py) begin
            w <= w - ACC_ONE;
          end else if (rd_y == py) begin
            hw <= hw - ACC_ONE;
          end
        end else begin
          if (rd_y > py) begin
            hw <= hw + ACC_ONE;
          end else if (rd_y < py) begin
            hw <= hw - ACC_ONE;
          end
        end
      end
    end
  end

  // hw/2 + hw%2 with truncation: ceiling of half for positive, floor for negative
  assign hw_half = (hw < 0) ? (hw >>> 1) : ((hw + ACC_ONE) >>> 1);
  assign total   = SW'(w) + SW'(hw_half);

  always_comb begin
    if (total > SAT_HI) begin
      sat = SAT_HI;
    end else if (total < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = total;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      if (hit) begin
        winding    <= WIND_W'(1);
        inside_res <= 1'b1;
      end else begin
        winding    <= sat[WIND_W-1:0];
        inside_res <= (sat != '0);
      end
      on_vertex  <= hit;
      overflowed <= ovf;
    end
  end

endmodule

### hw/rtl/polygon_winding_number.sv
// polygon_winding_number: top level of the winding-number point-in-polygon block
// joins the controller (pwn_ctrl) and the datapath (pwn_dp)
// depends on pwn_pkg, pwn_ctrl, pwn_dp
//
//  channel   direction  handshake            payload
//  request   in         start & !busy        req_type, coord_x, coord_y
//  result    out        done (one cycle)     winding, inside_res, on_vertex, overflowed
//
// append, clear and unused codes finish in the accepting cycle; busy stays low
// a query with n stored vertices (n >= 2) runs through these steps until done:
//   one vertex memory read per cycle walks the edges, then the sum state and the strobe
//   state follow; a hit on a vertex ends the walk early; fewer than two vertices skip the walk
// the walk is bounded by the single read port of the vertex memory
// rst is synchronous; it empties the polygon and clears the overflow flag
// the receiver cannot stall: each result is shown for exactly the cycle done is high
module polygon_winding_number #(
  parameter int MAX_VERTICES = pwn_pkg::DEF_MAX_VERTICES,
  parameter int COORD_BITS   = pwn_pkg::DEF_COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        req_type,
  input  logic signed [COORD_BITS-1:0]      coord_x,
  input  logic signed [COORD_BITS-1:0]      coord_y,
  output logic                              done,
  output logic signed [pwn_pkg::WIND_W-1:0] winding,
  output logic                              inside_res,
  output logic                              on_vertex,
  output logic                              overflowed
);
  import pwn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // request decode and sequencing
  pwn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  // vertex store, edge walk and result registers
  pwn_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .sts        (sts),
    .winding    (winding),
    .inside_res (inside_res),
    .on_vertex  (on_vertex),
    .overflowed (overflowed)
  );

  // a vertex hit always reports winding one
  a_hit_one: assert property (@(posedge clk) disable iff (rst)
    (done && on_vertex) |-> (winding == WIND_W'(1)))
    else $error("vertex hit without winding one");

  // inside flag tracks a nonzero winding
  a_inside: assert property (@(posedge clk) disable iff (rst)
    done |-> (inside_res == (winding != '0)))
    else $error("inside flag disagrees with winding");

  // an accepted query keeps the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_QUERY) |=> busy)
    else $error("query accepted but block not busy");

  // the result strobe lasts one cycle and comes while busy
  a_strobe: assert property (@(posedge clk) disable iff (rst)
    done |-> (busy && !$past(done)))
    else $error("result strobe malformed");

endmodule

### bench/tb_polygon_winding_number.sv
// tb_polygon_winding_number: self-checking bench for the winding-number block
// predicts each query result from its own copy of the vertex frame and compares
// depends on pwn_pkg and polygon_winding_number
module tb_polygon_winding_number;
  timeunit 1ns;
  timeprecision 1ps;

  import pwn_pkg::*;

  // code the block ignores, used as noise
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int CAPACITY   = DEF_MAX_VERTICES;
  localparam int CW         = DEF_COORD_BITS;
  // longest query walk plus sum and strobe cycles, with margin
  localparam int DRAIN_WAIT = CAPACITY + 40;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int MAX_PRINTS  = 40;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    logic signed [WIND_W-1:0] winding;
    logic                     nonzero;
    logic                     hit;
    logic                     ovf;
  } wind_result_t;

  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               req_type;
  coord_t                   coord_x;
  coord_t                   coord_y;
  logic                     done;
  logic signed [WIND_W-1:0] winding;
  logic                     inside_res;
  logic                     on_vertex;
  logic                     overflowed;

  // shadow copy of the vertex frame
  coord_t       frame_x [CAPACITY];
  coord_t       frame_y [CAPACITY];
  int           frame_count;
  logic         frame_ovf;

  // predicted query results, oldest first
  wind_result_t pending_answers [$];

  int           err_count;
  int           cycle_count = 0;
  int           idle_pct;

  polygon_winding_number u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .done       (done),
    .winding    (winding),
    .inside_res (inside_res),
    .on_vertex  (on_vertex),
    .overflowed (overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle counter and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t timeout after %0d cycles", $time, cycle_count);
    $display("[FAIL] regression broken");
    $finish;
  end

  // whole number to Q16.16
  function automatic coord_t to_fix(input int v);
    return coord_t'(v) <<< 16;
  endfunction

  // winding number of (px, py) against the shadow frame
  function automatic wind_result_t wind_predict(input coord_t px, input coord_t py);
    int           w;
    int           hw;
    int           wn;
    int           i;
    logic         hit;
    wind_result_t r;
    w   = 0;
    hw  = 0;
    hit = 1'b0;
    if (frame_count >= 2) begin
      for (i = 0; i + 1 < frame_count && !hit; i++) begin
        if (frame_x[i] == px && frame_y[i] == py) begin
          hit = 1'b1;
        end else if (frame_x[i] >= px) begin
          // edge start at or right of the point: classify by y
          if (frame_y[i] < py) begin
            if (frame_y[i+1] > py) w++;
            else if (frame_y[i+1] == py) hw++;
          end else if (frame_y[i] > py) begin
            if (frame_y[i+1] < py) w--;
            else if (frame_y[i+1] == py) hw--;
          end else begin
            if (frame_y[i+1] > py) hw++;
            else if (frame_y[i+1] < py) hw--;
          end
        end
      end
    end
    // truncating division, remainder takes the sign of hw
    wn = hit ? 1 : (w + hw / 2 + hw % 2);
    if (wn > WIND_MAX) wn = WIND_MAX;
    if (wn < -WIND_MAX) wn = -WIND_MAX;
    r.winding = wn[WIND_W-1:0];
    r.nonzero = (wn != 0);
    r.hit     = hit;
    r.ovf     = frame_ovf;
    return r;
  endfunction

  // update the shadow frame for one accepted request
  task automatic frame_apply(input logic [1:0] rq, input coord_t x, input coord_t y);
    case (rq)
      REQ_APPEND: begin
        if (frame_count < CAPACITY) begin
          frame_x[frame_count] = x;
          frame_y[frame_count] = y;
          frame_count++;
        end else begin
          frame_ovf = 1'b1;
        end
      end
      REQ_QUERY: begin
        pending_answers = {pending_answers, wind_predict(x, y)};
      end
      REQ_CLEAR: begin
        frame_count = 0;
        frame_ovf   = 1'b0;
      end
      default: ;
    endcase
  endtask

  // drive one request; start stays high until the next gap so no lower/raise in one step
  task automatic send_req(input logic [1:0] rq, input coord_t x, input coord_t y);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start    <= 1'b1;
    req_type <= rq;
    coord_x  <= x;
    coord_y  <= y;
    // accepted at the first edge with busy low
    @(posedge clk);
    while (busy) @(posedge clk);
    frame_apply(rq, x, y);
  endtask

  // sender pauses until every predicted result has arrived, then lets the walk settle
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // result checker: each strobe is matched against the oldest prediction
  always @(posedge clk) begin
    wind_result_t exp_r;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        err_count++;
        if (err_count <= MAX_PRINTS)
          $display("%0t unexpected result: w %0d in %0b hit %0b ovf %0b",
                   $time, winding, inside_res, on_vertex, overflowed);
      end else begin
        exp_r = pending_answers.pop_front();
        if (winding !== exp_r.winding || inside_res !== exp_r.nonzero ||
            on_vertex !== exp_r.hit || overflowed !== exp_r.ovf) begin
          err_count++;
          if (err_count <= MAX_PRINTS)
            $display({"%0t mismatch: expected w %0d in %0b hit %0b ovf %0b,",
                      " got w %0d in %0b hit %0b ovf %0b"},
                     $time, exp_r.winding, exp_r.nonzero, exp_r.hit, exp_r.ovf,
                     winding, inside_res, on_vertex, overflowed);
        end
      end
    end
  end

  // empty frame, single vertex, point equal to that lone vertex
  task automatic test_short_polygon();
    send_req(REQ_QUERY, to_fix(0), to_fix(0));
    send_req(REQ_CLEAR, to_fix(0), to_fix(0));
    send_req(REQ_QUERY, to_fix(3), to_fix(-3));
    send_req(REQ_APPEND, to_fix(1), to_fix(1));
    send_req(REQ_QUERY, to_fix(1), to_fix(1));
    send_req(REQ_QUERY, to_fix(0), to_fix(0));
    drain_results();
  endtask

  // closed square both ways round: inside, outside, vertex hit, last vertex, edge level
  task automatic test_square();
    send_req(REQ_CLEAR, to_fix(0), to_fix(0));
    send_req(REQ_APPEND, to_fix(0), to_fix(0));
    send_req(REQ_APPEND, to_fix(4), to_fix(0));
    send_req(REQ_APPEND, to_fix(4), to_fix(4));
    send_req(REQ_APPEND, to_fix(0), to_fix(4));
    send_req(REQ_APPEND, to_fix(0), to_fix(0));
    send_req(REQ_QUERY, to_fix(2), to_fix(2));
    send_req(REQ_QUERY, to_fix(4), to_fix(4));
    send_req(REQ_QUERY, to_fix(6), to_fix(2));
    send_req(REQ_QUERY, to_fix(-2), to_fix(4));
    send_req(REQ_QUERY, to_fix(2), to_fix(0));
    // last vertex: not a hit, crossing rule applies
    send_req(REQ_APPEND, to_fix(2), to_fix(2) + coord_t'(1));
    send_req(REQ_QUERY, to_fix(2), to_fix(2) + coord_t'(1));
    send_req(REQ_CLEAR, to_fix(0), to_fix(0));
    send_req(REQ_APPEND, to_fix(0), to_fix(0));
    send_req(REQ_APPEND, to_fix(0), to_fix(4));
    send_req(REQ_APPEND, to_fix(4), to_fix(4));
    send_req(REQ_APPEND, to_fix(4), to_fix(0));
    send_req(REQ_APPEND, to_fix(0), to_fix(0));
    send_req(REQ_QUERY, to_fix(1), to_fix(3));
    drain_results();
  endtask

  // coordinate extremes and the ignored request code
  task automatic test_extremes();
    send_req(REQ_CLEAR, C_MAX, C_MIN);
    send_req(REQ_APPEND, C_MIN, C_MIN);
    send_req(REQ_APPEND, C_MAX, C_MIN);
    send_req(REQ_APPEND, C_MAX, C_MAX);
    send_req(REQ_APPEND, C_MIN, C_MAX);
    send_req(REQ_APPEND, C_MIN, C_MIN);
    send_req(REQ_UNUSED, coord_t'(-1), coord_t'(-1));
    send_req(REQ_QUERY, coord_t'(0), coord_t'(0));
    send_req(REQ_QUERY, C_MAX, C_MAX);
    send_req(REQ_QUERY, C_MIN, C_MAX);
    send_req(REQ_QUERY, C_MAX, coord_t'(-1));
    send_req(REQ_QUERY, coord_t'(-1), C_MIN);
    drain_results();
  endtask

  // fill the store, then drop two appends; flag is sticky until clear
  task automatic test_overflow();
    int i;
    send_req(REQ_CLEAR, to_fix(0), to_fix(0));
    for (i = 0; i < CAPACITY; i++) begin
      send_req(REQ_APPEND, to_fix($urandom_range(0, 12) - 6), to_fix($urandom_range(0, 12) - 6));
    end
    send_req(REQ_QUERY, to_fix(0), to_fix(0));
    send_req(REQ_APPEND, to_fix(1), to_fix(1));
    send_req(REQ_QUERY, to_fix(1), to_fix(-1));
    send_req(REQ_APPEND, to_fix(2), to_fix(2));
    send_req(REQ_QUERY, to_fix(-3), to_fix(2));
    send_req(REQ_CLEAR, to_fix(0), to_fix(0));
    send_req(REQ_QUERY, to_fix(0), to_fix(0));
    drain_results();
  endtask

  // one coordinate: grid, grid with fraction, full width, or extreme
  function automatic coord_t pick_coord(input int mode);
    case (mode)
      0: return to_fix($urandom_range(0, 12) - 6);
      1: return to_fix($urandom_range(0, 8) - 4) + coord_t'($urandom_range(0, 3) << 14);
      2: return coord_t'($urandom());
      default: begin
        case ($urandom_range(0, 3))
          0: return C_MIN;
          1: return C_MAX;
          2: return coord_t'(0);
          default: return coord_t'(-1);
        endcase
      end
    endcase
  endfunction

  // mostly well-formed frames with queries near their vertices, some noise
  task automatic test_random(input int n_items, input int pct);
    coord_t seq_x [$];
    coord_t seq_y [$];
    int     sent;
    int     k;
    int     q;
    int     i;
    int     j;
    int     mode;
    idle_pct = pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 8) begin
        // noise: any code, any bits
        send_req(2'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
        sent++;
      end else begin
        seq_x.delete();
        seq_y.delete();
        mode = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1) : $urandom_range(2, 3);
        if ($urandom_range(0, 4) != 0) begin
          send_req(REQ_CLEAR, coord_t'($urandom()), coord_t'($urandom()));
          sent++;
        end
        k = ($urandom_range(0, 39) == 0) ? $urandom_range(100, CAPACITY + 4)
                                         : $urandom_range(0, 10);
        for (i = 0; i < k; i++) begin
          seq_x = {seq_x, pick_coord(mode)};
          seq_y = {seq_y, pick_coord(mode)};
          send_req(REQ_APPEND, seq_x[i], seq_y[i]);
          sent++;
        end
        // close the loop most of the time
        if (k > 1 && $urandom_range(0, 3) != 0) begin
          send_req(REQ_APPEND, seq_x[0], seq_y[0]);
          sent++;
        end
        q = $urandom_range(1, 6);
        for (i = 0; i < q; i++) begin
          if (k > 0 && $urandom_range(0, 3) == 0) begin
            j = $urandom_range(0, k - 1);
            send_req(REQ_QUERY, seq_x[j], seq_y[j]);
          end else if (k > 0 && $urandom_range(0, 3) == 0) begin
            // share one coordinate with a vertex to hit the level cases
            j = $urandom_range(0, k - 1);
            send_req(REQ_QUERY, pick_coord(mode), seq_y[j]);
          end else begin
            send_req(REQ_QUERY, pick_coord(mode), pick_coord(mode));
          end
          sent++;
        end
      end
    end
    drain_results();
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    req_type    = REQ_APPEND;
    coord_x     = '0;
    coord_y     = '0;
    frame_count = 0;
    frame_ovf   = 1'b0;
    err_count   = 0;
    idle_pct    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed checks with a light sender gap mix
    idle_pct = 20;
    test_short_polygon();
    test_square();
    test_extremes();
    test_overflow();

    // random phases: no gaps, heavy gaps, no gaps again (the receiver cannot stall), light gaps
    test_random(70, 0);
    test_random(70, 75);
    test_random(50, 0);
    test_random(60, 8);

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0t %0d errors", $time, err_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
